/* hw/rtl/qcci_pkg.sv */
// ----------------------------------------------------------------------------
// qcci_pkg
// Types and constants shared by the Q15 complex channel inverter.
// ----------------------------------------------------------------------------
package qcci_pkg;

   localparam int MAX_SHIFT_DEFAULT = 14;
   localparam int Q15_BITS          = 15;
   localparam int QUEUE_DEPTH       = 2;
   localparam int QUO_W             = 16;

   localparam logic signed [15:0] REF_REAL_RESET = 16'sd16384;
   localparam logic signed [15:0] REF_IMAG_RESET = 16'sd0;

   // register indexes on the csr port
   localparam logic REG_REF_REAL = 1'b0;
   localparam logic REG_REF_IMAG = 1'b1;

   typedef struct packed {
      logic signed [15:0] chan_real;
      logic signed [15:0] chan_imag;
   } req_type;

   typedef struct packed {
      logic signed [15:0] inv_real;
      logic signed [15:0] inv_imag;
      logic [3:0]         scale_shift;
      logic               not_found;
   } rsp_type;

   // unshifted products: |chan|^2, ref.chan* real and imaginary parts
   typedef struct packed {
      logic [31:0]        pwr;
      logic signed [32:0] re;
      logic signed [32:0] im;
   } prod_type;

endpackage

/* hw/rtl/qcci_fifo.sv */
// ----------------------------------------------------------------------------
// qcci_fifo
// Short queue of product sets between the front and back parts.
// ----------------------------------------------------------------------------
module qcci_fifo
   import qcci_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  prod_type push_data,
   output logic     full,
   output logic     valid,
   input  logic     pop,
   output prod_type pop_data
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

   prod_type         mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hw/rtl/qcci_front.sv */
// ----------------------------------------------------------------------------
// qcci_front
// Takes a channel estimate and forms |chan|^2 and ref.chan* with one shared
// 16x16 multiplier, one product per step, then pushes the set into the queue.
// ----------------------------------------------------------------------------
module qcci_front
   import qcci_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_type            req_data,
   input  logic signed [15:0] ref_real,
   input  logic signed [15:0] ref_imag,
   output logic               q_push,
   output prod_type           q_data,
   input  logic               q_full
);

   localparam logic [2:0] STEP_PWR_A = 3'd0;
   localparam logic [2:0] STEP_PWR_B = 3'd1;
   localparam logic [2:0] STEP_RE_A  = 3'd2;
   localparam logic [2:0] STEP_RE_B  = 3'd3;
   localparam logic [2:0] STEP_IM_A  = 3'd4;
   localparam logic [2:0] STEP_IM_B  = 3'd5;

   logic               busy_ff, busy_in;
   logic [2:0]         step_ff, step_in;
   logic signed [15:0] cr_ff, ci_ff;
   logic signed [32:0] acc_ff, acc_in;
   logic [31:0]        pwr_ff;
   logic signed [32:0] re_ff;
   logic signed [15:0] op_a, op_b;
   logic signed [31:0] prod;
   logic signed [32:0] prod_x;
   logic               accept, advance;

   assign req_stall = busy_ff;
   assign accept    = req_valid && !busy_ff;

   always_comb begin
      case (step_ff)
         STEP_PWR_A: begin op_a = cr_ff;    op_b = cr_ff; end
         STEP_PWR_B: begin op_a = ci_ff;    op_b = ci_ff; end
         STEP_RE_A:  begin op_a = ref_real; op_b = cr_ff; end
         STEP_RE_B:  begin op_a = ref_imag; op_b = ci_ff; end
         STEP_IM_A:  begin op_a = ref_imag; op_b = cr_ff; end
         STEP_IM_B:  begin op_a = ref_real; op_b = ci_ff; end
         default:    begin op_a = '0;       op_b = '0;    end
      endcase
   end

   assign prod   = op_a * op_b;
   assign prod_x = {prod[31], prod};

   // even steps start a sum, odd steps finish it
   always_comb begin
      if (!step_ff[0]) begin
         acc_in = prod_x;
      end else if (step_ff == STEP_IM_B) begin
         acc_in = acc_ff - prod_x;
      end else begin
         acc_in = acc_ff + prod_x;
      end
   end

   assign q_push         = busy_ff && (step_ff == STEP_IM_B) && !q_full;
   assign q_data.pwr     = pwr_ff;
   assign q_data.re      = re_ff;
   assign q_data.im      = acc_in;
   assign advance        = busy_ff && ((step_ff != STEP_IM_B) || !q_full);

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (accept) begin
         busy_in = 1'b1;
         step_in = STEP_PWR_A;
      end else if (advance) begin
         if (step_ff == STEP_IM_B) begin
            busy_in = 1'b0;
            step_in = STEP_PWR_A;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= STEP_PWR_A;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cr_ff <= req_data.chan_real;
         ci_ff <= req_data.chan_imag;
      end
      if (advance) begin
         acc_ff <= acc_in;
         if (step_ff == STEP_PWR_B) begin
            pwr_ff <= acc_in[31:0];
         end
         if (step_ff == STEP_RE_B) begin
            re_ff <= acc_in;
         end
      end
   end

endmodule

/* hw/rtl/qcci_back.sv */
// ----------------------------------------------------------------------------
// qcci_back
// Shift search over the queued products; if a shift passes, two restoring
// dividers in parallel, one quotient bit per cycle; then the output register.
// ----------------------------------------------------------------------------
module qcci_back
   import qcci_pkg::*;
#(
   parameter int MAX_SHIFT = MAX_SHIFT_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     q_valid,
   input  prod_type q_data,
   output logic     q_pop,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   // shifting chan by s scales p by 4^s and re, im by 2^s
   localparam int P_W = 32 + 2 * (MAX_SHIFT - 1);
   localparam int M_W = 32 + (MAX_SHIFT - 1);
   localparam logic [3:0] LAST_SHIFT = 4'(MAX_SHIFT - 1);
   localparam logic [3:0] LAST_BIT   = 4'(QUO_W - 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_DIVIDE = 2'd2;
   localparam logic [1:0] ST_DONE   = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [P_W-1:0]   pwr_ff;
   logic [M_W-1:0]   rmag_ff, imag_ff;
   logic             rneg_ff, ineg_ff;
   logic [3:0]       shift_ff;
   logic [P_W-1:0]   dsh_ff;
   logic [P_W-1:0]   rrem_ff, irem_ff;
   logic [QUO_W-1:0] rquo_ff, iquo_ff;
   logic [3:0]       cnt_ff;
   logic             fail_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;

   logic [32:0]      re_abs, im_abs;
   logic             r_ok, i_ok, d_nz, pass;
   logic             r_ge, i_ge;
   logic             out_free;
   logic [QUO_W-1:0] res_re, res_im;
   logic [3:0]       res_shift;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign q_pop     = (state_ff == ST_IDLE) && q_valid;

   assign re_abs = q_data.re[32] ? 33'(-q_data.re) : 33'(q_data.re);
   assign im_abs = q_data.im[32] ? 33'(-q_data.im) : 33'(q_data.im);

   assign r_ok = P_W'(rmag_ff) < pwr_ff;
   assign i_ok = P_W'(imag_ff) < pwr_ff;
   assign d_nz = |pwr_ff[P_W-1:Q15_BITS];
   assign pass = r_ok && i_ok && d_nz;

   assign r_ge = rrem_ff >= dsh_ff;
   assign i_ge = irem_ff >= dsh_ff;

   assign res_re    = rneg_ff ? QUO_W'(-rquo_ff) : rquo_ff;
   assign res_im    = ineg_ff ? QUO_W'(-iquo_ff) : iquo_ff;
   assign res_shift = (fail_ff || shift_ff == '0) ? 4'd0 : shift_ff - 4'd1;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (pass) begin
               state_in = ST_DIVIDE;
            end else if (shift_ff == LAST_SHIFT) begin
               state_in = ST_DONE;
            end
         end
         ST_DIVIDE: begin
            if (cnt_ff == LAST_BIT) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            pwr_ff   <= P_W'(q_data.pwr);
            rmag_ff  <= M_W'(re_abs[31:0]);
            imag_ff  <= M_W'(im_abs[31:0]);
            rneg_ff  <= q_data.re[32];
            ineg_ff  <= q_data.im[32];
            shift_ff <= '0;
            fail_ff  <= 1'b0;
         end
         ST_SEARCH: begin
            if (pass) begin
               dsh_ff  <= {pwr_ff[P_W-1:Q15_BITS], Q15_BITS'(0)};
               rrem_ff <= P_W'(rmag_ff);
               irem_ff <= P_W'(imag_ff);
               cnt_ff  <= '0;
            end else if (shift_ff == LAST_SHIFT) begin
               fail_ff <= 1'b1;
               rquo_ff <= '0;
               iquo_ff <= '0;
               rneg_ff <= 1'b0;
               ineg_ff <= 1'b0;
            end else begin
               pwr_ff   <= pwr_ff << 2;
               rmag_ff  <= rmag_ff << 1;
               imag_ff  <= imag_ff << 1;
               shift_ff <= shift_ff + 4'd1;
            end
         end
         ST_DIVIDE: begin
            if (r_ge) begin
               rrem_ff <= rrem_ff - dsh_ff;
            end
            if (i_ge) begin
               irem_ff <= irem_ff - dsh_ff;
            end
            rquo_ff <= {rquo_ff[QUO_W-2:0], r_ge};
            iquo_ff <= {iquo_ff[QUO_W-2:0], i_ge};
            dsh_ff  <= dsh_ff >> 1;
            cnt_ff  <= cnt_ff + 4'd1;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_ff.inv_real    <= res_re;
               rsp_ff.inv_imag    <= res_im;
               rsp_ff.scale_shift <= res_shift;
               rsp_ff.not_found   <= fail_ff;
            end
         end
         default: ;
      endcase
   end

endmodule

/* hw/rtl/q15_complex_channel_inverter_top.sv */
// ----------------------------------------------------------------------------
// q15_complex_channel_inverter_top
// Scaled Q15 inverse of a complex channel estimate: ref / chan.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one channel estimate per transfer; rsp_* returns one result
//   per estimate, in order. Both use valid/stall; a result sits in the output
//   register until the receiver drops rsp_stall.
//   csr_* writes the reference phasor (index 0 real, index 1 imaginary); write
//   only while no estimate is in flight.
// Path: multiply-accumulate in the front (one shared 16x16 multiplier), the
//   queue and load into the back part, 1 to MAX_SHIFT shift trials, the
//   divide (one quotient bit per cycle, both parts in parallel) and the
//   output register; the divide is skipped when no shift passes.
// The back part sets the rate of items and the front fills the queue
//   meanwhile, so the front can take a new estimate while the back part
//   still works on earlier ones.
// Reset clears the queue, control state and output valid, and loads the
//   reference phasor with 0.5 + 0j. A stalled receiver holds the result; the
//   queue then fills and req_stall rises.
// ----------------------------------------------------------------------------
module q15_complex_channel_inverter_top
   import qcci_pkg::*;
#(
   parameter int MAX_SHIFT = MAX_SHIFT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   logic signed [15:0] ref_real_ff;
   logic signed [15:0] ref_imag_ff;
   logic               q_push, q_full, q_valid, q_pop;
   prod_type           q_in, q_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_real_ff <= REF_REAL_RESET;
         ref_imag_ff <= REF_IMAG_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_REF_REAL: ref_real_ff <= csr_wdata;
            REG_REF_IMAG: ref_imag_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   qcci_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .ref_real  (ref_real_ff),
      .ref_imag  (ref_imag_ff),
      .q_push    (q_push),
      .q_data    (q_in),
      .q_full    (q_full)
   );

   qcci_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .valid     (q_valid),
      .pop       (q_pop),
      .pop_data  (q_out)
   );

   qcci_back #(
      .MAX_SHIFT (MAX_SHIFT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_out),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
